// ===== hw/rtl/trapf_pkg.sv =====
// shared constants and controller/datapath interface types for the packet framer
package trapf_pkg;

    localparam logic [7:0] START_CHAR = 8'h24;
    localparam logic [7:0] END_CHAR   = 8'h0A;
    localparam int         LEN_W      = 7;

    localparam logic KIND_FWD   = 1'b0;
    localparam logic KIND_LOCAL = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd_pos;
        logic upd_cnt;
        logic close;
        logic fwd_clear;
        logic fwd_read;
        logic fwd_next;
        logic load_fwd;
        logic load_local;
    } t_cmd;

    typedef struct packed {
        logic done_hop;
        logic done_local;
        logic match;
        logic fwd_last;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/trapf_ctrl.sv =====
// sequencing state machine of the packet framer
module trapf_ctrl
    import trapf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDPOS = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_LOCAL = 3'd3;
    localparam logic [2:0] S_FRD   = 3'd4;
    localparam logic [2:0] S_FLD   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.done_hop) begin
                        n_state = S_RDPOS;
                    end else if (i_sts.done_local) begin
                        n_state = S_LOCAL;
                    end
                end
            end
            S_RDPOS: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.upd_cnt = 1'b1;
                if (i_sts.match) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_LOCAL;
                end else begin
                    o_cmd.fwd_clear = 1'b1;
                    n_state         = S_FRD;
                end
            end
            S_LOCAL: begin
                if (i_sts.out_free) begin
                    o_cmd.load_local = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.fwd_read = 1'b1;
                n_state        = S_FLD;
            end
            S_FLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_fwd = 1'b1;
                    if (i_sts.fwd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.fwd_next = 1'b1;
                        n_state        = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/trapf_dp.sv =====
// packet store, write pointer, hop counter update and output register
module trapf_dp
    import trapf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int COUNTER_POS  = 2,
    parameter int TARGET_POS   = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [LEN_W-1:0] o_packet_length,
    output logic             o_last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int WW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [AW-1:0] CPOS = AW'(COUNTER_POS % BUFFER_DEPTH);
    localparam logic [AW-1:0] TPOS = AW'(TARGET_POS % BUFFER_DEPTH);
    localparam logic SAME_POS = ((COUNTER_POS % BUFFER_DEPTH) == (TARGET_POS % BUFFER_DEPTH));

    logic [7:0]        r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_vld;
    logic              r_in_pkt;
    logic [WW-1:0]     r_widx;
    logic              r_enable;
    logic [7:0]        r_rd_a;
    logic [7:0]        r_rd_t;
    logic [AW-1:0]     r_fidx;
    logic              r_o_valid;
    logic              r_kind;
    logic [7:0]        r_byte;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;

    logic              is_start;
    logic              is_end;
    logic              full;
    logic              acc_write;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [7:0]        mem_wd;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [7:0]        cnt_next;

    assign is_start  = (i_rx_byte == START_CHAR);
    assign is_end    = (i_rx_byte == END_CHAR);
    assign full      = (r_widx >= WW'(BUFFER_DEPTH));
    assign acc_write = i_cmd.accept && (is_start || (r_in_pkt && !full));
    assign cnt_next  = r_rd_a + 8'd1;

    assign mem_we = acc_write || i_cmd.upd_cnt;
    assign mem_wa = i_cmd.upd_cnt ? CPOS : (is_start ? '0 : r_widx[AW-1:0]);
    assign mem_wd = i_cmd.upd_cnt ? cnt_next : i_rx_byte;

    assign rd_en   = i_cmd.rd_pos || i_cmd.fwd_read;
    assign rd_addr = i_cmd.rd_pos ? CPOS : r_fidx;

    // packet store, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_a <= r_vld[rd_addr] ? r_mem[rd_addr] : 8'd0;
        end
        if (i_cmd.rd_pos) begin
            r_rd_t <= r_vld[TPOS] ? r_mem[TPOS] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_in_pkt  <= 1'b0;
            r_widx    <= '0;
            r_enable  <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                if (is_start) begin
                    r_in_pkt <= 1'b1;
                    r_widx   <= WW'(1);
                end else if (r_in_pkt) begin
                    if (full) begin
                        r_in_pkt <= 1'b0;
                    end else begin
                        r_widx <= r_widx + WW'(1);
                        if (is_end && !r_enable) begin
                            r_in_pkt <= 1'b0;
                        end
                    end
                end
            end
            if (i_cmd.close) begin
                r_in_pkt <= 1'b0;
            end
            if (i_cmd.load_fwd || i_cmd.load_local) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fwd_clear) begin
            r_fidx <= '0;
        end else if (i_cmd.fwd_next) begin
            r_fidx <= r_fidx + AW'(1);
        end
        if (i_cmd.load_local) begin
            r_kind <= KIND_LOCAL;
            r_byte <= 8'd0;
            r_len  <= LEN_W'(r_widx);
            r_last <= 1'b1;
        end else if (i_cmd.load_fwd) begin
            r_kind <= KIND_FWD;
            r_byte <= r_rd_a;
            r_len  <= LEN_W'(r_widx);
            r_last <= o_sts.fwd_last;
        end
    end

    assign o_sts.done_hop   = acc_write && !is_start && is_end && r_enable;
    assign o_sts.done_local = acc_write && !is_start && is_end && !r_enable;
    assign o_sts.match      = SAME_POS || (cnt_next == r_rd_t);
    assign o_sts.fwd_last   = ((WW'(r_fidx) + WW'(1)) == r_widx);
    assign o_sts.out_free   = !r_o_valid || !i_stall;

    assign o_valid         = r_o_valid;
    assign o_out_kind      = r_kind;
    assign o_out_byte      = r_byte;
    assign o_packet_length = r_len;
    assign o_last          = r_last;

endmodule

// ===== hw/rtl/token_ring_ascii_packet_framer.sv =====
// Token-ring ASCII packet framer: a '$' opens a packet at any time, later bytes are
// stored, and a newline closes it. In token-ring mode the hop counter byte is
// incremented and compared with the target byte; a match gives one packet-ready
// transaction, a mismatch forwards the whole stored packet as byte transactions and
// leaves the packet open. A packet that overflows the store is dropped silently.
// An ordinary byte is accepted without stalling the input. A newline with token ring off
// waits for a free output; with token ring on the counter is read and then updated,
// and forwarding then does one store read and one output load per stored byte, the
// input stalling until the last stored byte is loaded into the output register.
// The store starts as all zeros through per-entry valid bits; no clearing pass.
module token_ring_ascii_packet_framer
    import trapf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64,
    parameter int COUNTER_POS  = 2,
    parameter int TARGET_POS   = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [LEN_W-1:0] o_packet_length,
    output logic             o_last,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    trapf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    trapf_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .COUNTER_POS  (COUNTER_POS),
        .TARGET_POS   (TARGET_POS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_kind      (o_out_kind),
        .o_out_byte      (o_out_byte),
        .o_packet_length (o_packet_length),
        .o_last          (o_last)
    );

endmodule

// ===== tb/tb_top.sv =====
// testbench for the token ring packet framer: directed and random byte streams against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trapf_pkg::*;

    localparam int FRAME_DEPTH = 64;
    localparam int HOP_POS     = 2 % FRAME_DEPTH;
    localparam int DEST_POS    = 3 % FRAME_DEPTH;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last_flag;
    } t_frame_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic [7:0]       i_rx_byte     = 8'h00;
    logic             i_stall       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic             i_cfg_wr_data = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic             o_out_kind;
    logic [7:0]       o_out_byte;
    logic [LEN_W-1:0] o_packet_length;
    logic             o_last;

    // predictor state
    logic [7:0]    frame_store [FRAME_DEPTH];
    logic          frame_open  = 1'b0;
    int            frame_wr    = 0;
    logic          ring_mode   = 1'b1;
    t_frame_result pending_results[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int tx_idle_pct   = 6;
    int rx_idle_pct   = 58;

    token_ring_ascii_packet_framer #(
        .BUFFER_DEPTH (FRAME_DEPTH),
        .COUNTER_POS  (2),
        .TARGET_POS   (3)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_kind      (o_out_kind),
        .o_out_byte      (o_out_byte),
        .o_packet_length (o_packet_length),
        .o_last          (o_last),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < rx_idle_pct);
    end

    function automatic void predict_frame_output(input logic [7:0] b);
        t_frame_result r;
        if (b == START_CHAR) begin
            frame_open     = 1'b1;
            frame_store[0] = b;
            frame_wr       = 1;
            return;
        end
        if (!frame_open) return;
        if (frame_wr >= FRAME_DEPTH) begin
            frame_open = 1'b0;
            return;
        end
        frame_store[frame_wr] = b;
        frame_wr++;
        if (b != END_CHAR) return;
        if (ring_mode) begin
            frame_store[HOP_POS] = frame_store[HOP_POS] + 8'd1;
            if (frame_store[HOP_POS] != frame_store[DEST_POS]) begin
                for (int i = 0; i < frame_wr; i++) begin
                    r.kind      = KIND_FWD;
                    r.data      = frame_store[i];
                    r.len       = LEN_W'(frame_wr);
                    r.last_flag = (i + 1 == frame_wr);
                    pending_results.push_back(r);
                end
                return;
            end
        end
        frame_open  = 1'b0;
        r.kind      = KIND_LOCAL;
        r.data      = 8'h00;
        r.len       = LEN_W'(frame_wr);
        r.last_flag = 1'b1;
        pending_results.push_back(r);
    endfunction

    // predict on input transactions, check output transactions
    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_DEPTH; i++) frame_store[i] = 8'h00;
            frame_open = 1'b0;
            frame_wr   = 0;
            ring_mode  = 1'b1;
        end else begin
            if (i_cfg_wr_en) ring_mode = i_cfg_wr_data;
            if (i_valid && !o_stall) predict_frame_output(i_rx_byte);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected transaction: kind %0d byte %02h length %0d last %0d",
                           o_out_kind, o_out_byte, o_packet_length, o_last);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_kind !== want.kind) begin
                        $error("out_kind: expected %0d, got %0d", want.kind, o_out_kind);
                        fail_count++;
                    end
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                        fail_count++;
                    end
                    if (o_packet_length !== want.len) begin
                        $error("packet_length: expected %0d, got %0d",
                               want.len, o_packet_length);
                        fail_count++;
                    end
                    if (o_last !== want.last_flag) begin
                        $error("last: expected %0d, got %0d", want.last_flag, o_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == START_CHAR || b == END_CHAR);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_packet(input logic [7:0] src, input logic [7:0] hop,
                               input logic [7:0] dest, input int nbody);
        send_byte(START_CHAR);
        send_byte(src);
        send_byte(hop);
        send_byte(dest);
        repeat (nbody) send_byte(body_byte());
        send_byte(END_CHAR);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_ring_mode(input logic mode);
        wait_drained();
        repeat (200) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = mode;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic test_outside_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_CHAR);
    endtask

    // counter and target still zero from reset
    task automatic test_unwritten_fields();
        send_byte(START_CHAR);
        send_byte(END_CHAR);
    endtask

    task automatic test_local_match();
        send_packet(8'h41, 8'h05, 8'h06, 0);
    endtask

    task automatic test_forward_kept_open();
        send_packet(8'h41, 8'h05, 8'h09, 1);
        send_byte(8'h00);
        send_byte(END_CHAR);
        send_byte(END_CHAR);
        send_byte(END_CHAR);
    endtask

    task automatic test_restart_mid_packet();
        send_byte(START_CHAR);
        send_byte(8'h10);
        send_packet(8'h01, 8'h00, 8'h01, 0);
    endtask

    task automatic test_counter_wrap();
        send_packet(8'h00, 8'hFF, 8'h00, 0);
    endtask

    task automatic test_ring_off();
        set_ring_mode(1'b0);
        send_packet(8'h7F, 8'h80, 8'h33, 0);
        send_byte(START_CHAR);
        send_byte(END_CHAR);
        set_ring_mode(1'b1);
    endtask

    task automatic test_store_overflow();
        // full-size packet forwarded, then the next byte overflows
        send_packet(8'h5A, 8'h10, 8'h30, FRAME_DEPTH - 5);
        send_byte(8'h55);
        send_byte(END_CHAR);
        // store fills without a newline
        send_byte(START_CHAR);
        repeat (FRAME_DEPTH - 1) send_byte(body_byte());
        send_byte(END_CHAR);
        set_ring_mode(1'b0);
        send_packet(8'hA5, 8'h10, 8'h30, FRAME_DEPTH - 5);
        set_ring_mode(1'b1);
    endtask

    task automatic run_random_traffic(input int n_items);
        int         stop_at;
        int         pick;
        int         nbody;
        logic [7:0] hop;
        logic [7:0] dest;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                hop = body_byte();
                if ($urandom_range(1)) begin
                    dest = hop + 8'd1;
                    if (dest == START_CHAR || dest == END_CHAR) dest = body_byte();
                end else begin
                    dest = body_byte();
                end
                nbody = ($urandom_range(9) == 0) ? $urandom_range(62) : $urandom_range(6);
                send_packet(body_byte(), hop, dest, nbody);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
            end else begin
                // broken packet, left open or restarted
                send_byte(START_CHAR);
                repeat ($urandom_range(0, 4)) send_byte(body_byte());
            end
        end
    endtask

    task automatic test_random_phases();
        tx_idle_pct = 6;
        rx_idle_pct = 58;
        run_random_traffic(40);
        wait_drained();
        run_random_traffic(40);

        set_ring_mode(1'b0);
        tx_idle_pct = 58;
        rx_idle_pct = 6;
        run_random_traffic(80);

        set_ring_mode(1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_traffic(80);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_outside_bytes();
        test_unwritten_fields();
        test_local_match();
        test_forward_kept_open();
        test_restart_mid_packet();
        test_counter_wrap();
        test_ring_off();
        test_store_overflow();
        test_random_phases();

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected transactions never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/trapf_pkg.sv
hw/rtl/trapf_ctrl.sv
hw/rtl/trapf_dp.sv
hw/rtl/token_ring_ascii_packet_framer.sv
tb/tb_top.sv
